### src/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// Types and fixed constants shared by the range statistics engine.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  // Function codes, read on the last word of a range.
  localparam logic [2:0] ACT_MIN   = 3'd0;
  localparam logic [2:0] ACT_MAX   = 3'd1;
  localparam logic [2:0] ACT_SUM   = 3'd2;
  localparam logic [2:0] ACT_AVG   = 3'd3;
  localparam logic [2:0] ACT_STDEV = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ERR  = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;

  // The mean needs one division step per bit of the 32-bit magnitude.
  localparam int MEAN_STEPS = 32;

  typedef struct packed {
    logic signed [31:0] cell_value;
    logic               cell_error;
    logic               last_cell;
    logic [2:0]         action;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic div_load_mean;
    logic div_load_q;
    logic div_step;
    logic mean_latch;
    logic rd_first;
    logic rd;
    logic sqrt_load;
    logic sqrt_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic       err_nz;
    logic [2:0] act;
    logic       cnt_gt1;
    logic       pass_last;
    logic       pipe_busy;
  } stat_t;

endpackage

### src/range_statistics_engine.sv
// ----------------------------------------------------------------------------
// range_statistics_engine
// MIN, MAX, SUM, AVG or population STDEV over a range of cell values.
// ----------------------------------------------------------------------------
//  Channel | Ports                       | Handshake
//  --------+-----------------------------+----------------------------------
//  input   | start, busy, in_data        | taken when start high, busy low
//  result  | out_strobe, out_data        | one-cycle strobe, never held off
//
// Cells load one per cycle; busy stays low until the last word of a range.
// MIN, MAX, SUM and any error result go from the decide state straight to emit.
// AVG runs the mean through the one-bit-a-cycle divider (32 steps). STDEV runs
// the mean division, one store read per cell, a second division of 4*S by n
// and the square root two bits a cycle. Reset is synchronous and clears the
// range; the value store is not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module range_statistics_engine #(
  parameter int MAX_CELLS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rse_pkg::in_item_t  in_data,
  output logic               out_strobe,
  output rse_pkg::out_item_t out_data
);

  rse_pkg::cmd_t  cmd;
  rse_pkg::stat_t stat;

  rse_ctrl #(.MAX_CELLS(MAX_CELLS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_cell (in_data.last_cell),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  rse_dp #(.MAX_CELLS(MAX_CELLS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

### src/rse_dp.sv
// ----------------------------------------------------------------------------
// rse_dp
// Datapath: value store, running sum/min/max/count, shared restoring divider,
// second-pass squared-deviation pipeline and bit-pair square root.
// ----------------------------------------------------------------------------
module rse_dp #(
  parameter int MAX_CELLS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rse_pkg::in_item_t in_data,
  input  rse_pkg::cmd_t     cmd,
  output rse_pkg::stat_t    stat,
  output logic              out_strobe,
  output rse_pkg::out_item_t out_data
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int SW = 64 + AW;
  localparam int QW = SW + 2;
  localparam int RW = (QW + 1) / 2;

  logic [31:0]        store [MAX_CELLS];
  logic [CW-1:0]      count_r, count_nxt;
  logic [31:0]        sum_r, sum_nxt;
  logic signed [31:0] min_r, min_nxt, max_r, max_nxt;
  logic [1:0]         err_r, err_nxt;
  logic [2:0]         act_r;
  logic [AW-1:0]      rd_addr_r;
  logic [31:0]        rdata_r;
  logic [3:0]         v_r;
  logic signed [32:0] d_r;
  logic [31:0]        m_r;
  logic [63:0]        p_r;
  logic [SW-1:0]      acc_r;
  logic [CW-1:0]      rem_r;
  logic [QW-1:0]      quo_r;
  logic               neg_r;
  logic signed [32:0] mean_r;
  logic [RW+1:0]      srem_r;
  logic [2*RW-1:0]    rad_r;
  logic [RW-1:0]      root_r;
  rse_pkg::out_item_t out_r;
  logic               out_v_r;

  logic               full;
  logic [31:0]        abs_sum;
  logic [CW:0]        dsh, ddiff;
  logic               dge;
  logic [32:0]        qmag;
  logic signed [32:0] dval;
  logic [RW+3:0]      ssh, strial, sdiff;
  logic               sge;
  logic [RW:0]        rnd;
  logic signed [31:0] stdev;
  logic signed [31:0] res;

  assign full    = (count_r == CW'(MAX_CELLS));
  assign abs_sum = sum_r[31] ? (~sum_r + 32'd1) : sum_r;

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    err_nxt   = err_r;
    if (cmd.emit) begin
      count_nxt = '0;
      sum_nxt   = '0;
      min_nxt   = rse_pkg::INT_MAX;
      max_nxt   = rse_pkg::INT_MIN;
      err_nxt   = rse_pkg::ST_OK;
    end else if (cmd.load) begin
      if (in_data.cell_error) begin
        err_nxt = rse_pkg::ST_ERR;
      end else if (full && err_r == rse_pkg::ST_OK) begin
        err_nxt = rse_pkg::ST_OVER;
      end
      if (!full) begin
        count_nxt = count_r + CW'(1);
      end
      sum_nxt = sum_r + in_data.cell_value;
      if (in_data.cell_value < min_r) begin
        min_nxt = in_data.cell_value;
      end
      if (in_data.cell_value > max_r) begin
        max_nxt = in_data.cell_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      min_r   <= rse_pkg::INT_MAX;
      max_r   <= rse_pkg::INT_MIN;
      err_r   <= rse_pkg::ST_OK;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_data.action;
    end
  end

  // Value store: one write port while loading, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      store[count_r[AW-1:0]] <= in_data.cell_value;
    end
    if (cmd.rd) begin
      rdata_r <= store[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      rd_addr_r <= '0;
    end else if (cmd.rd) begin
      rd_addr_r <= rd_addr_r + AW'(1);
    end
  end

  // Deviation pipeline: read, subtract mean, magnitude, square, accumulate.
  assign dval = $signed({rdata_r[31], rdata_r}) - mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], cmd.rd};
    end
  end

  always_ff @(posedge clk) begin
    d_r <= dval;
    m_r <= d_r[32] ? 32'(-d_r) : d_r[31:0];
    p_r <= m_r * m_r;
    if (cmd.mean_latch) begin
      acc_r <= '0;
    end else if (v_r[3]) begin
      acc_r <= acc_r + SW'(p_r);
    end
  end

  // Restoring divider by the cell count, one quotient bit a cycle.
  assign dsh   = {rem_r, quo_r[QW-1]};
  assign dge   = (dsh >= {1'b0, count_r});
  assign ddiff = dsh - {1'b0, count_r};
  assign qmag  = {1'b0, quo_r[31:0]};

  always_ff @(posedge clk) begin
    if (cmd.div_load_mean) begin
      rem_r <= '0;
      quo_r <= {abs_sum, (QW-32)'(0)};
      neg_r <= sum_r[31];
    end else if (cmd.div_load_q) begin
      rem_r <= '0;
      quo_r <= {acc_r, 2'b00};
    end else if (cmd.div_step) begin
      rem_r <= dge ? ddiff[CW-1:0] : dsh[CW-1:0];
      quo_r <= {quo_r[QW-2:0], dge};
    end
    if (cmd.mean_latch) begin
      mean_r <= neg_r ? -$signed(qmag) : $signed(qmag);
    end
  end

  // Square root of floor(4S/n), two radicand bits a cycle.
  assign ssh    = {srem_r, rad_r[2*RW-1 -: 2]};
  assign strial = (RW+4)'({root_r, 2'b01});
  assign sge    = (ssh >= strial);
  assign sdiff  = ssh - strial;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      srem_r <= '0;
      root_r <= '0;
      rad_r  <= (2*RW)'(quo_r);
    end else if (cmd.sqrt_step) begin
      srem_r <= sge ? sdiff[RW+1:0] : ssh[RW+1:0];
      root_r <= {root_r[RW-2:0], sge};
      rad_r  <= {rad_r[2*RW-3:0], 2'b00};
    end
  end

  // Largest odd u with u*u <= Q is the root or one below it; r = (u+1)/2.
  assign rnd   = ({1'b0, root_r} + (RW+1)'(1)) >> 1;
  assign stdev = (rnd > (RW+1)'(rse_pkg::INT_MAX)) ? rse_pkg::INT_MAX : $signed(rnd[31:0]);

  always_comb begin
    res = '0;
    if (err_r == rse_pkg::ST_OK) begin
      case (act_r)
        rse_pkg::ACT_MIN:   res = min_r;
        rse_pkg::ACT_MAX:   res = max_r;
        rse_pkg::ACT_SUM:   res = $signed(sum_r);
        rse_pkg::ACT_AVG:   res = mean_r[31:0];
        rse_pkg::ACT_STDEV: res = (count_r > CW'(1)) ? stdev : '0;
        default:            res = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.result_value <= res;
      out_r.status       <= err_r;
    end
  end

  assign out_strobe     = out_v_r;
  assign out_data       = out_r;
  assign stat.err_nz    = (err_r != rse_pkg::ST_OK);
  assign stat.act       = act_r;
  assign stat.cnt_gt1   = (count_r > CW'(1));
  assign stat.pass_last = (CW'(rd_addr_r) == count_r - CW'(1));
  assign stat.pipe_busy = |v_r;

endmodule

### src/rse_ctrl.sv
// ----------------------------------------------------------------------------
// rse_ctrl
// Controller: accepts words while idle and sequences the division, the
// second pass over the store and the square root after the last word.
// ----------------------------------------------------------------------------
module rse_ctrl #(
  parameter int MAX_CELLS = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           last_cell,
  input  rse_pkg::stat_t stat,
  output logic           busy,
  output rse_pkg::cmd_t  cmd
);

  localparam int AW  = $clog2(MAX_CELLS);
  localparam int QW  = 66 + AW;
  localparam int RW  = (QW + 1) / 2;
  localparam int STW = $clog2(QW);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_MDIV   = 4'd2;
  localparam logic [3:0] S_MEAN   = 4'd3;
  localparam logic [3:0] S_PASS   = 4'd4;
  localparam logic [3:0] S_DRAIN  = 4'd5;
  localparam logic [3:0] S_QDIV   = 4'd6;
  localparam logic [3:0] S_RLOAD  = 4'd7;
  localparam logic [3:0] S_ROOT   = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0]     state_r, state_nxt;
  logic [STW-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
        if (start && last_cell) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        step_nxt = '0;
        if (!stat.err_nz && (stat.act == rse_pkg::ACT_AVG ||
            (stat.act == rse_pkg::ACT_STDEV && stat.cnt_gt1))) begin
          cmd.div_load_mean = 1'b1;
          state_nxt         = S_MDIV;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_MDIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STW'(1);
        if (step_r == STW'(rse_pkg::MEAN_STEPS - 1)) begin
          state_nxt = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd.mean_latch = 1'b1;
        cmd.rd_first   = 1'b1;
        state_nxt      = (stat.act == rse_pkg::ACT_AVG) ? S_EMIT : S_PASS;
      end
      S_PASS: begin
        cmd.rd = 1'b1;
        if (stat.pass_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        step_nxt = '0;
        if (!stat.pipe_busy) begin
          cmd.div_load_q = 1'b1;
          state_nxt      = S_QDIV;
        end
      end
      S_QDIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STW'(1);
        if (step_r == STW'(QW - 1)) begin
          state_nxt = S_RLOAD;
        end
      end
      S_RLOAD: begin
        cmd.sqrt_load = 1'b1;
        step_nxt      = '0;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.sqrt_step = 1'b1;
        step_nxt      = step_r + STW'(1);
        if (step_r == STW'(RW - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |=> (state_r == S_IDLE))
    else $error("emit state did not return to idle");

  a_decide_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |-> ($past(cmd.load) && $past(last_cell)))
    else $error("result sequence began without a last word");

  a_mdiv_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MDIV) |=> (state_r == S_MDIV || state_r == S_MEAN))
    else $error("mean division left early");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PASS || state_r == S_ROOT) |-> !cmd.load)
    else $error("word loaded during computation");

endmodule

### tb/range_statistics_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_statistics_engine_tb
// Drives ranges of cell words into the engine and checks every statistic.
// A directed opening covers the extremes, each function, error and overflow
// ranges, and then random ranges follow with random gaps between words.
// ----------------------------------------------------------------------------

class range_scoreboard;
  localparam int DEPTH = 1024;

  logic [31:0]        cell_store [DEPTH];
  logic [31:0]        wrap_sum;
  logic signed [31:0] low_val;
  logic signed [31:0] high_val;
  int                 held;
  logic [1:0]         fault;
  rse_pkg::out_item_t expected_q[$];
  int                 failures;
  int                 checked;

  function new();
    failures = 0;
    checked  = 0;
    clear();
  endfunction

  function void clear();
    wrap_sum = '0;
    low_val  = rse_pkg::INT_MAX;
    high_val = rse_pkg::INT_MIN;
    held     = 0;
    fault    = rse_pkg::ST_OK;
  endfunction

  // Population deviation around the truncated mean, rounded half away from
  // zero: the largest r with n*(2r-1)^2 <= 4*S.
  function logic signed [31:0] deviation(int n);
    longint       mean;
    longint       d;
    logic [127:0] sq_sum;
    logic [127:0] trial;
    longint       lo;
    longint       hi;
    longint       mid;
    mean   = longint'($signed(wrap_sum)) / longint'(n);
    sq_sum = '0;
    for (int i = 0; i < n; i++) begin
      d = longint'($signed(cell_store[i])) - mean;
      if (d < 0) d = -d;
      trial  = 128'(d);
      sq_sum = sq_sum + trial * trial;
    end
    sq_sum = sq_sum << 2;
    lo = 0;
    hi = 64'h1_0000_0000;
    while (lo < hi) begin
      mid   = lo + (hi - lo + 1) / 2;
      trial = 128'(2 * mid - 1);
      trial = trial * trial * 128'(n);
      if (trial <= sq_sum) lo = mid;
      else hi = mid - 1;
    end
    return (lo > 64'h7FFF_FFFF) ? rse_pkg::INT_MAX : 32'(lo);
  endfunction

  function void note_word(rse_pkg::in_item_t w);
    rse_pkg::out_item_t r;
    if (w.cell_error) fault = rse_pkg::ST_ERR;
    if (held < DEPTH) begin
      cell_store[held] = w.cell_value;
      held++;
    end else if (fault == rse_pkg::ST_OK) begin
      fault = rse_pkg::ST_OVER;
    end
    wrap_sum = wrap_sum + w.cell_value;
    if (w.cell_value < low_val)  low_val  = w.cell_value;
    if (w.cell_value > high_val) high_val = w.cell_value;
    if (!w.last_cell) return;
    r.status       = fault;
    r.result_value = '0;
    if (fault == rse_pkg::ST_OK) begin
      case (w.action)
        rse_pkg::ACT_MIN:   r.result_value = low_val;
        rse_pkg::ACT_MAX:   r.result_value = high_val;
        rse_pkg::ACT_SUM:   r.result_value = wrap_sum;
        rse_pkg::ACT_AVG:
          r.result_value = 32'(longint'($signed(wrap_sum)) / longint'(held));
        rse_pkg::ACT_STDEV: r.result_value = (held <= 1) ? 32'sd0 : deviation(held);
        default:            r.result_value = '0;
      endcase
    end
    expected_q.push_back(r);
    clear();
  endfunction

  function void check_result(rse_pkg::out_item_t got);
    rse_pkg::out_item_t want;
    checked++;
    if (expected_q.size() == 0) begin
      $error("unexpected result: result_value %0d status %0d",
             got.result_value, got.status);
      failures++;
      return;
    end
    want = expected_q.pop_front();
    if (got.result_value !== want.result_value) begin
      $error("result_value: expected %0d, got %0d", want.result_value, got.result_value);
      failures++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      failures++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module range_statistics_engine_tb;
  localparam longint CYCLE_LIMIT = 3_000_000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  rse_pkg::in_item_t  in_data;
  logic               out_strobe;
  rse_pkg::out_item_t out_data;

  range_scoreboard sb;
  longint          cycles;
  int              words_sent;
  int              ranges_sent;

  range_statistics_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_word(in_data);
    if (rst_n && out_strobe) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out waiting for the engine.");
      $display("Test completed with failures");
      $finish;
    end
  end

  // Holds start high across back-to-back words; lowers it only for a gap.
  task automatic send_word(input rse_pkg::in_item_t w, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic send_range(input logic signed [31:0] vals[$], input logic [2:0] act,
                            input int err_at, input bit gaps);
    rse_pkg::in_item_t w;
    for (int i = 0; i < vals.size(); i++) begin
      w.cell_value = vals[i];
      w.cell_error = (i == err_at);
      w.last_cell  = (i == vals.size() - 1);
      w.action     = w.last_cell ? act : 3'($urandom_range(0, 7));
      send_word(w, gaps ? $urandom_range(0, 4) : 0);
    end
    ranges_sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return rse_pkg::INT_MAX - 32'($urandom_range(0, 3));
      1:       return rse_pkg::INT_MIN + 32'($urandom_range(0, 3));
      2, 3:    return 32'($signed(32'($urandom_range(0, 200))) - 100);
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    logic signed [31:0] vals[$];
    int                 len;
    logic [2:0]         act;
    sb          = new();
    cycles      = 0;
    words_sent  = 0;
    ranges_sent = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single cells at the extremes, with MIN, MAX and STDEV.
    vals = '{rse_pkg::INT_MAX};
    send_range(vals, rse_pkg::ACT_MIN, -1, 0);
    vals = '{rse_pkg::INT_MIN};
    send_range(vals, rse_pkg::ACT_MAX, -1, 0);
    vals = '{rse_pkg::INT_MIN};
    send_range(vals, rse_pkg::ACT_STDEV, -1, 0);
    // The sum wraps; the average truncates toward zero.
    vals = '{rse_pkg::INT_MAX, rse_pkg::INT_MAX, 32'sd5};
    send_range(vals, rse_pkg::ACT_SUM, -1, 0);
    vals = '{-32'sd7, 32'sd0, 32'sd2};
    send_range(vals, rse_pkg::ACT_AVG, -1, 0);
    // Deviation across the extremes saturates.
    vals = '{rse_pkg::INT_MIN, rse_pkg::INT_MAX};
    send_range(vals, rse_pkg::ACT_STDEV, -1, 0);
    vals = '{32'sd1, 32'sd2, 32'sd3, 32'sd4};
    send_range(vals, rse_pkg::ACT_STDEV, -1, 0);
    // Error cells, and unused function codes.
    vals = '{32'sd9, 32'sd1};
    send_range(vals, rse_pkg::ACT_MAX, 0, 0);
    vals = '{32'sd3};
    send_range(vals, 3'd5, -1, 0);
    vals = '{32'sd3, -32'sd3};
    send_range(vals, 3'd7, -1, 0);

    // A range one word past capacity.
    vals.delete();
    for (int i = 0; i < 1025; i++) vals.push_back(pick_value());
    send_range(vals, rse_pkg::ACT_SUM, -1, 0);

    // Let everything drain once before the random part.
    drain();

    while (words_sent < 1400) begin
      vals.delete();
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) vals.push_back(pick_value());
      act = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      send_range(vals, act, ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1,
                 1'b1);
    end

    drain();
    $display("Sent %0d words in %0d ranges; %0d results checked.",
             words_sent, ranges_sent, sb.checked);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

### sim.f
src/rse_pkg.sv
src/rse_dp.sv
src/rse_ctrl.sv
src/range_statistics_engine.sv
tb/range_statistics_engine_tb.sv
